FILE: hw/rtl/obc_pkg.sv
// Shared types and constants for the world bounds clamp.
// No dependencies; every other file refers to this package by scoped names.
package obc_pkg;

    localparam int COORD_W    = 32;
    localparam int MAG_W      = 31;
    localparam int COMP_W     = 18;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = MAG_W + COMP_W;
    localparam int TERM_W     = PROD_W - FRAC_W;
    localparam int EXT_W      = TERM_W + 2;
    localparam int THRESH_W   = COORD_W + 1;
    localparam int WIDE_W     = 40;
    localparam int AXIS_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic signed [COORD_W-1:0] BOUND_MIN_RESET = 32'sd0;
    localparam logic signed [COORD_W-1:0] BOUND_MAX_RESET = 32'sd6553600;

    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef enum logic [AXIS_W-1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5,
        REG_SLOP  = 3'd6,
        REG_NONE  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
        logic [MAG_W-1:0]          slop;
    } cfg_t;

    // word from the front stage, through the queue, into the back end
    typedef struct packed {
        logic                       active;
        logic                       sphere;
        logic [MAG_W-1:0]           radius;
        logic [TERM_W-1:0]          term_a;
        logic [TERM_W-1:0]          term_b;
        logic [TERM_W-1:0]          term_c;
        logic signed [COORD_W-1:0]  pos;
        logic signed [COORD_W-1:0]  vel;
        logic signed [COORD_W-1:0]  lo;
        logic signed [COORD_W-1:0]  hi;
        logic signed [THRESH_W-1:0] thresh;
    } front_word_t;

    // word between the lower and upper correction stages
    typedef struct packed {
        logic                      active;
        logic [EXT_W-1:0]          ext;
        wide_t                     pos;
        logic signed [COORD_W-1:0] vel;
        logic signed [COORD_W-1:0] hi;
        logic                      wake;
    } mid_word_t;

endpackage

FILE: hw/rtl/obc_if.sv
// Channel interfaces (valid/ready) for input items and result items.
// Depends on obc_pkg for field widths.
interface obc_item_if;
    logic                               valid;
    logic                               ready;
    logic [obc_pkg::AXIS_W-1:0]         axis_sel;
    logic                               body_static;
    logic                               body_sphere;
    logic [obc_pkg::MAG_W-1:0]          sphere_radius;
    logic [obc_pkg::MAG_W-1:0]          half_ext_a;
    logic [obc_pkg::MAG_W-1:0]          half_ext_b;
    logic [obc_pkg::MAG_W-1:0]          half_ext_c;
    logic signed [obc_pkg::COMP_W-1:0]  axis_comp_a;
    logic signed [obc_pkg::COMP_W-1:0]  axis_comp_b;
    logic signed [obc_pkg::COMP_W-1:0]  axis_comp_c;
    logic signed [obc_pkg::COORD_W-1:0] position;
    logic signed [obc_pkg::COORD_W-1:0] velocity;

    modport source (
        output valid, axis_sel, body_static, body_sphere, sphere_radius,
               half_ext_a, half_ext_b, half_ext_c, axis_comp_a, axis_comp_b,
               axis_comp_c, position, velocity,
        input  ready
    );
    modport sink (
        input  valid, axis_sel, body_static, body_sphere, sphere_radius,
               half_ext_a, half_ext_b, half_ext_c, axis_comp_a, axis_comp_b,
               axis_comp_c, position, velocity,
        output ready
    );
endinterface

interface obc_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [obc_pkg::COORD_W-1:0] new_position;
    logic signed [obc_pkg::COORD_W-1:0] new_velocity;
    logic                               wake;

    modport source (
        output valid, new_position, new_velocity, wake,
        input  ready
    );
    modport sink (
        input  valid, new_position, new_velocity, wake,
        output ready
    );
endinterface

FILE: hw/rtl/obc_front.sv
// Front stage: accepts items, picks the axis bounds, forms the box products.
// Depends on obc_pkg and obc_item_if.
module obc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    obc_item_if.sink             item,
    input  obc_pkg::cfg_t        cfg,
    output obc_pkg::front_word_t word,
    output logic                 word_valid,
    input  logic                 word_ready
);

    logic                 valid_reg;
    logic                 valid_next;
    obc_pkg::front_word_t word_reg;
    obc_pkg::front_word_t word_next;
    logic                 take;

    logic [obc_pkg::COMP_W-1:0] mag_a;
    logic [obc_pkg::COMP_W-1:0] mag_b;
    logic [obc_pkg::COMP_W-1:0] mag_c;
    logic [obc_pkg::PROD_W-1:0] prod_a;
    logic [obc_pkg::PROD_W-1:0] prod_b;
    logic [obc_pkg::PROD_W-1:0] prod_c;

    assign item.ready = !valid_reg || word_ready;
    assign take       = item.valid && item.ready;

    // -2.0 negates to the 18-bit pattern of +2.0 read unsigned
    assign mag_a  = item.axis_comp_a[obc_pkg::COMP_W-1] ? (~item.axis_comp_a + 1'b1)
                                                        : item.axis_comp_a;
    assign mag_b  = item.axis_comp_b[obc_pkg::COMP_W-1] ? (~item.axis_comp_b + 1'b1)
                                                        : item.axis_comp_b;
    assign mag_c  = item.axis_comp_c[obc_pkg::COMP_W-1] ? (~item.axis_comp_c + 1'b1)
                                                        : item.axis_comp_c;
    assign prod_a = item.half_ext_a * mag_a;
    assign prod_b = item.half_ext_b * mag_b;
    assign prod_c = item.half_ext_c * mag_c;

    always_comb
    begin
        word_next        = word_reg;
        word_next.sphere = item.body_sphere;
        word_next.radius = item.sphere_radius;
        word_next.term_a = prod_a[obc_pkg::PROD_W-1:obc_pkg::FRAC_W];
        word_next.term_b = prod_b[obc_pkg::PROD_W-1:obc_pkg::FRAC_W];
        word_next.term_c = prod_c[obc_pkg::PROD_W-1:obc_pkg::FRAC_W];
        word_next.pos    = item.position;
        word_next.vel    = item.velocity;
        word_next.active = !item.body_static;
        case (obc_pkg::axis_t'(item.axis_sel))
            obc_pkg::AXIS_X:
            begin
                word_next.lo = cfg.min_x;
                word_next.hi = cfg.max_x;
            end
            obc_pkg::AXIS_Y:
            begin
                word_next.lo = cfg.min_y;
                word_next.hi = cfg.max_y;
            end
            obc_pkg::AXIS_Z:
            begin
                word_next.lo = cfg.min_z;
                word_next.hi = cfg.max_z;
            end
            default:
            begin
                word_next.lo     = cfg.min_x;
                word_next.hi     = cfg.max_x;
                word_next.active = 1'b0;
            end
        endcase
        // slop widens the lower threshold on Y only
        if (obc_pkg::axis_t'(item.axis_sel) == obc_pkg::AXIS_Y)
        begin
            word_next.thresh = {word_next.lo[obc_pkg::COORD_W-1], word_next.lo}
                             - {2'b00, cfg.slop};
        end
        else
        begin
            word_next.thresh = {word_next.lo[obc_pkg::COORD_W-1], word_next.lo};
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (word_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= word_next;
        end
    end

    assign word       = word_reg;
    assign word_valid = valid_reg;

endmodule

FILE: hw/rtl/obc_queue.sv
// Two-word queue between the front stage and the back end.
// Depends on obc_pkg.
module obc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  obc_pkg::front_word_t push_word,
    input  logic                 push_valid,
    output logic                 push_ready,
    output obc_pkg::front_word_t pop_word,
    output logic                 pop_valid,
    input  logic                 pop_ready
);

    localparam int DEPTH = 2;

    obc_pkg::front_word_t mem [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_word   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

FILE: hw/rtl/obc_back.sv
// Back end: extent (box sum or sphere radius) and lower correction, then upper correction,
// saturation and the result register. Depends on obc_pkg, obc_result_if.
module obc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  obc_pkg::front_word_t word,
    input  logic                 word_valid,
    output logic                 word_ready,
    obc_result_if.source         result
);

    localparam int SAT_W = obc_pkg::WIDE_W - obc_pkg::COORD_W + 1;

    logic                 mid_valid_reg;
    logic                 mid_valid_next;
    obc_pkg::mid_word_t   mid_reg;
    obc_pkg::mid_word_t   mid_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic signed [obc_pkg::COORD_W-1:0] pos_out_reg;
    logic signed [obc_pkg::COORD_W-1:0] pos_out_next;
    logic signed [obc_pkg::COORD_W-1:0] vel_out_reg;
    logic signed [obc_pkg::COORD_W-1:0] vel_out_next;
    logic                 wake_out_reg;
    logic                 wake_out_next;
    logic                 mid_ready;
    logic                 take_a;
    logic                 take_b;

    logic [obc_pkg::EXT_W-1:0] ext;
    obc_pkg::wide_t ext_w;
    obc_pkg::wide_t pos_w;
    obc_pkg::wide_t lo_w;
    obc_pkg::wide_t thresh_w;
    logic           lo_fire;
    obc_pkg::wide_t mid_ext_w;
    obc_pkg::wide_t hi_w;
    obc_pkg::wide_t pos_hi;
    logic           hi_fire;
    logic [SAT_W-1:0] top_bits;

    assign mid_ready  = !out_valid_reg || result.ready;
    assign word_ready = !mid_valid_reg || mid_ready;
    assign take_a     = word_valid && word_ready;
    assign take_b     = mid_valid_reg && mid_ready;

    // lower end
    always_comb
    begin
        if (word.sphere)
        begin
            ext = obc_pkg::EXT_W'(word.radius);
        end
        else
        begin
            ext = obc_pkg::EXT_W'(word.term_a) + obc_pkg::EXT_W'(word.term_b)
                + obc_pkg::EXT_W'(word.term_c);
        end
        ext_w    = obc_pkg::wide_t'({1'b0, ext});
        pos_w    = obc_pkg::wide_t'(word.pos);
        lo_w     = obc_pkg::wide_t'(word.lo);
        thresh_w = obc_pkg::wide_t'(word.thresh);
        lo_fire  = word.active && ((pos_w - ext_w) < thresh_w);

        mid_next.active = word.active;
        mid_next.ext    = ext;
        mid_next.hi     = word.hi;
        mid_next.wake   = lo_fire;
        mid_next.pos    = lo_fire ? (lo_w + ext_w) : pos_w;
        mid_next.vel    = (lo_fire && word.vel[obc_pkg::COORD_W-1]) ? '0 : word.vel;
    end

    // upper end on the corrected position
    always_comb
    begin
        mid_ext_w     = obc_pkg::wide_t'({1'b0, mid_reg.ext});
        hi_w          = obc_pkg::wide_t'(mid_reg.hi);
        hi_fire       = mid_reg.active && ((mid_reg.pos + mid_ext_w) > hi_w);
        pos_hi        = hi_fire ? (hi_w - mid_ext_w) : mid_reg.pos;
        vel_out_next  = (hi_fire && !mid_reg.vel[obc_pkg::COORD_W-1]) ? '0 : mid_reg.vel;
        wake_out_next = mid_reg.wake || hi_fire;
        top_bits      = pos_hi[obc_pkg::WIDE_W-1:obc_pkg::COORD_W-1];
        if (top_bits == '0 || top_bits == '1)
        begin
            pos_out_next = pos_hi[obc_pkg::COORD_W-1:0];
        end
        else if (pos_hi[obc_pkg::WIDE_W-1])
        begin
            pos_out_next = {1'b1, {(obc_pkg::COORD_W-1){1'b0}}};
        end
        else
        begin
            pos_out_next = {1'b0, {(obc_pkg::COORD_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        mid_valid_next = take_a ? 1'b1 : (mid_ready ? 1'b0 : mid_valid_reg);
        out_valid_next = take_b ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_a)
        begin
            mid_reg <= mid_next;
        end
        if (take_b)
        begin
            pos_out_reg  <= pos_out_next;
            vel_out_reg  <= vel_out_next;
            wake_out_reg <= wake_out_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.new_position = pos_out_reg;
    assign result.new_velocity = vel_out_reg;
    assign result.wake         = wake_out_reg;

endmodule

FILE: hw/rtl/obb_world_bounds_clamp.sv
// World bounds clamp: per body axis, moves a body back inside the world box.
// Item path: front register, queue, mid register and result register, in that order.
// Throughput: one item per cycle; the front register, 2-word queue and two
// back stages each hand over a word per cycle while the result side takes it.
// Reset (rst_n low, async): all words dropped, bounds back to 0 / 100.0,
// floor slop 0. Depends on obc_pkg, obc_if, obc_front, obc_queue, obc_back.
module obb_world_bounds_clamp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [obc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [obc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    obc_item_if.sink                         item,
    obc_result_if.source                     result
);

    obc_pkg::cfg_t        cfg_reg;
    obc_pkg::cfg_t        cfg_next;
    obc_pkg::front_word_t front_word;
    logic                 front_valid;
    logic                 front_ready;
    obc_pkg::front_word_t queue_word;
    logic                 queue_valid;
    logic                 queue_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (obc_pkg::cfg_reg_t'(cfg_index))
                obc_pkg::REG_MIN_X: cfg_next.min_x = cfg_wdata;
                obc_pkg::REG_MIN_Y: cfg_next.min_y = cfg_wdata;
                obc_pkg::REG_MIN_Z: cfg_next.min_z = cfg_wdata;
                obc_pkg::REG_MAX_X: cfg_next.max_x = cfg_wdata;
                obc_pkg::REG_MAX_Y: cfg_next.max_y = cfg_wdata;
                obc_pkg::REG_MAX_Z: cfg_next.max_z = cfg_wdata;
                obc_pkg::REG_SLOP:  cfg_next.slop  = cfg_wdata[obc_pkg::MAG_W-1:0];
                default:            cfg_next       = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_x <= obc_pkg::BOUND_MIN_RESET;
            cfg_reg.min_y <= obc_pkg::BOUND_MIN_RESET;
            cfg_reg.min_z <= obc_pkg::BOUND_MIN_RESET;
            cfg_reg.max_x <= obc_pkg::BOUND_MAX_RESET;
            cfg_reg.max_y <= obc_pkg::BOUND_MAX_RESET;
            cfg_reg.max_z <= obc_pkg::BOUND_MAX_RESET;
            cfg_reg.slop  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    obc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg_reg),
        .word       (front_word),
        .word_valid (front_valid),
        .word_ready (front_ready)
    );

    obc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_word  (front_word),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_word   (queue_word),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    obc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .word       (queue_word),
        .word_valid (queue_valid),
        .word_ready (queue_ready),
        .result     (result)
    );

endmodule

FILE: hw/rtl/obc_checker.sv
// Port-level checks for the world bounds clamp, bound to the top level.
// Depends on obc_pkg and obb_world_bounds_clamp.
module obc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               item_valid,
    input logic                               item_ready,
    input logic                               result_valid,
    input logic                               result_ready,
    input logic signed [obc_pkg::COORD_W-1:0] new_position,
    input logic signed [obc_pkg::COORD_W-1:0] new_velocity,
    input logic                               wake
);

    // words held inside: front 1, queue 2, back 2
    localparam int CAPACITY = 5;

    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    assign inflight_next = inflight_reg + 3'(item_valid && item_ready)
                         - 3'(result_valid && result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 3'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // checked with a non-overlapping implication so the very first reset edge is settled
    a_no_result_in_reset: assert property (@(posedge clk) !rst_n |=> !result_valid)
        else $error("result valid during reset");

    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> inflight_reg != 3'd0)
        else $error("result word with no item inside");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'(CAPACITY))
        else $error("more words inside than the pipeline holds");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(new_position)
        && $stable(new_velocity) && $stable(wake))
        else $error("stalled result word changed");

endmodule

bind obb_world_bounds_clamp obc_checker u_obc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .new_position (result.new_position),
    .new_velocity (result.new_velocity),
    .wake         (result.wake)
);

FILE: bench/obb_world_bounds_clamp_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for obb_world_bounds_clamp: directed and random body-axis words
// against a clamp predictor, with random idling on both channels. Needs obc_pkg, obc_if
// and the clamp RTL.
module obb_world_bounds_clamp_tb;

    typedef logic [obc_pkg::MAG_W-1:0]            mag_t;
    typedef logic signed [obc_pkg::COMP_W-1:0]    comp_t;
    typedef logic signed [obc_pkg::COORD_W-1:0]   coord_t;

    localparam int  ONE           = 1 << obc_pkg::FRAC_W;
    localparam int  COORD_LO      = 32'h8000_0000;
    localparam int  COORD_HI      = 32'h7FFF_FFFF;
    localparam int  MAG_HI        = 32'h7FFF_FFFF;
    localparam int  PIPE_LATENCY  = 4;
    localparam int  CYCLE_LIMIT   = 200000;
    localparam longint POS_MAX    = 64'sd2147483647;
    localparam longint POS_MIN    = -64'sd2147483648;

    typedef struct {
        obc_pkg::axis_t axis_sel;
        logic           body_static;
        logic           body_sphere;
        mag_t           sphere_radius;
        mag_t           half_ext_a;
        mag_t           half_ext_b;
        mag_t           half_ext_c;
        comp_t          axis_comp_a;
        comp_t          axis_comp_b;
        comp_t          axis_comp_c;
        coord_t         position;
        coord_t         velocity;
    } body_item_t;

    typedef struct {
        coord_t new_position;
        coord_t new_velocity;
        logic   wake;
    } clamp_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    obc_pkg::cfg_reg_t              cfg_index;
    logic [obc_pkg::CFG_DATA_W-1:0] cfg_wdata;

    obc_item_if   item_ch ();
    obc_result_if res_ch ();

    obb_world_bounds_clamp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (res_ch)
    );

    // shadow copy of the bound registers
    coord_t cfg_min [3];
    coord_t cfg_max [3];
    mag_t   cfg_slop;

    clamp_result_t pending_results [$];
    int            fail_count  = 0;
    int            cycle_count = 0;
    bit            steady      = 1'b0;

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[obb_world_bounds_clamp] ERROR");
            $finish;
        end
    end

    function automatic longint box_term(mag_t half, comp_t comp);
        longint c;
        c = longint'(comp);
        if (c < 0)
            c = -c;
        return (longint'(half) * c) >>> obc_pkg::FRAC_W;
    endfunction

    function automatic longint body_extent(body_item_t b);
        if (b.body_sphere)
            return longint'(b.sphere_radius);
        return box_term(b.half_ext_a, b.axis_comp_a) + box_term(b.half_ext_b, b.axis_comp_b) +
               box_term(b.half_ext_c, b.axis_comp_c);
    endfunction

    function automatic clamp_result_t predict_clamp(body_item_t b);
        clamp_result_t r;
        longint pos, vel, ext, lo, hi, thresh;
        int ax;
        pos    = longint'(b.position);
        vel    = longint'(b.velocity);
        r.wake = 1'b0;
        if (!b.body_static && b.axis_sel != obc_pkg::AXIS_NONE)
        begin
            ax     = int'(b.axis_sel);
            ext    = body_extent(b);
            lo     = longint'(cfg_min[ax]);
            hi     = longint'(cfg_max[ax]);
            thresh = (b.axis_sel == obc_pkg::AXIS_Y) ? lo - longint'(cfg_slop) : lo;
            if (pos - ext < thresh)
            begin
                pos = lo + ext;
                if (vel < 0)
                    vel = 0;
                r.wake = 1'b1;
            end
            // upper check runs on the corrected position
            if (pos + ext > hi)
            begin
                pos = hi - ext;
                if (vel > 0)
                    vel = 0;
                r.wake = 1'b1;
            end
            if (pos > POS_MAX)
                pos = POS_MAX;
            if (pos < POS_MIN)
                pos = POS_MIN;
        end
        r.new_position = pos[31:0];
        r.new_velocity = vel[31:0];
        return r;
    endfunction

    always @(posedge clk)
    begin : check_results
        clamp_result_t exp_r;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing outstanding");
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (res_ch.new_position !== exp_r.new_position)
                begin
                    $error("new_position: expected %0d, actual %0d",
                           exp_r.new_position, res_ch.new_position);
                    fail_count++;
                end
                if (res_ch.new_velocity !== exp_r.new_velocity)
                begin
                    $error("new_velocity: expected %0d, actual %0d",
                           exp_r.new_velocity, res_ch.new_velocity);
                    fail_count++;
                end
                if (res_ch.wake !== exp_r.wake)
                begin
                    $error("wake: expected %0d, actual %0d", exp_r.wake, res_ch.wake);
                    fail_count++;
                end
            end
        end
    end

    // result side: random stall before taking each word
    initial
    begin : result_sink
        int stall;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic drive_payload(body_item_t b);
        item_ch.axis_sel      = b.axis_sel;
        item_ch.body_static   = b.body_static;
        item_ch.body_sphere   = b.body_sphere;
        item_ch.sphere_radius = b.sphere_radius;
        item_ch.half_ext_a    = b.half_ext_a;
        item_ch.half_ext_b    = b.half_ext_b;
        item_ch.half_ext_c    = b.half_ext_c;
        item_ch.axis_comp_a   = b.axis_comp_a;
        item_ch.axis_comp_b   = b.axis_comp_b;
        item_ch.axis_comp_c   = b.axis_comp_c;
        item_ch.position      = b.position;
        item_ch.velocity      = b.velocity;
    endtask

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_body(body_item_t b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        drive_payload(b);
        item_ch.valid = 1'b1;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_clamp(b));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        item_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (2 * PIPE_LATENCY) @(negedge clk);
    endtask

    task automatic write_reg(obc_pkg::cfg_reg_t idx, logic [obc_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        case (idx)
            obc_pkg::REG_MIN_X: cfg_min[0] = value;
            obc_pkg::REG_MIN_Y: cfg_min[1] = value;
            obc_pkg::REG_MIN_Z: cfg_min[2] = value;
            obc_pkg::REG_MAX_X: cfg_max[0] = value;
            obc_pkg::REG_MAX_Y: cfg_max[1] = value;
            obc_pkg::REG_MAX_Z: cfg_max[2] = value;
            obc_pkg::REG_SLOP:  cfg_slop   = value[obc_pkg::MAG_W-1:0];
            default:   ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic apply_bounds(int mn_x, int mn_y, int mn_z, int mx_x, int mx_y, int mx_z,
                                int slop);
        write_reg(obc_pkg::REG_MIN_X, mn_x);
        write_reg(obc_pkg::REG_MIN_Y, mn_y);
        write_reg(obc_pkg::REG_MIN_Z, mn_z);
        write_reg(obc_pkg::REG_MAX_X, mx_x);
        write_reg(obc_pkg::REG_MAX_Y, mx_y);
        write_reg(obc_pkg::REG_MAX_Z, mx_z);
        write_reg(obc_pkg::REG_SLOP, slop & MAG_HI);
    endtask

    function automatic body_item_t make_body(obc_pkg::axis_t ax, bit st, bit sph, int radius,
                                             int ha, int hb, int hc, int ca, int cb, int cc,
                                             int pos, int vel);
        body_item_t b;
        b.axis_sel      = ax;
        b.body_static   = st;
        b.body_sphere   = sph;
        b.sphere_radius = mag_t'(radius);
        b.half_ext_a    = mag_t'(ha);
        b.half_ext_b    = mag_t'(hb);
        b.half_ext_c    = mag_t'(hc);
        b.axis_comp_a   = comp_t'(ca);
        b.axis_comp_b   = comp_t'(cb);
        b.axis_comp_c   = comp_t'(cc);
        b.position      = pos;
        b.velocity      = vel;
        return b;
    endfunction

    function automatic body_item_t sphere_body(obc_pkg::axis_t ax, int radius, int pos,
                                               int vel);
        return make_body(ax, 1'b0, 1'b1, radius, 0, 0, 0, 0, 0, 0, pos, vel);
    endfunction

    function automatic mag_t random_mag();
        case ($urandom_range(0, 9))
            0:       return mag_t'($urandom);
            1:       return mag_t'($urandom_range(0, 1) ? MAG_HI : 0);
            default: return mag_t'($urandom_range(0, 30 * ONE));
        endcase
    endfunction

    function automatic comp_t random_comp();
        case ($urandom_range(0, 9))
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       return comp_t'(-2 * ONE);
                    1:       return comp_t'(-ONE);
                    2:       return comp_t'(ONE);
                    default: return '0;
                endcase
            end
            8, 9:    return comp_t'($urandom);
            default: return comp_t'($urandom_range(0, 2 * ONE) - ONE);
        endcase
    endfunction

    // positions mostly land just around one of the two clamp edges
    function automatic body_item_t random_body();
        body_item_t b;
        longint ext, lo, hi, target, delta;
        int mode, ax;
        b.axis_sel      = ($urandom_range(0, 19) == 0) ? obc_pkg::AXIS_NONE
                                                       : obc_pkg::axis_t'($urandom_range(0, 2));
        b.body_static   = ($urandom_range(0, 9) == 0);
        b.body_sphere   = 1'($urandom_range(0, 1));
        b.sphere_radius = random_mag();
        b.half_ext_a    = random_mag();
        b.half_ext_b    = random_mag();
        b.half_ext_c    = random_mag();
        b.axis_comp_a   = random_comp();
        b.axis_comp_b   = random_comp();
        b.axis_comp_c   = random_comp();
        b.velocity      = $urandom_range(0, 1) ? $urandom
                                               : $urandom_range(0, 20 * ONE) - 10 * ONE;
        ax  = (b.axis_sel == obc_pkg::AXIS_NONE) ? 0 : int'(b.axis_sel);
        ext = body_extent(b);
        lo  = longint'(cfg_min[ax]);
        if (ax == 1 && $urandom_range(0, 1))
            lo = lo - longint'(cfg_slop);
        hi  = longint'(cfg_max[ax]);
        if ($urandom_range(0, 3) == 0)
            delta = longint'($urandom_range(0, 4)) - 2;
        else
            delta = longint'($urandom_range(0, 6 * ONE)) - 3 * ONE;
        mode = $urandom_range(0, 9);
        if (mode <= 2)
            target = lo + ext + delta;
        else if (mode <= 5)
            target = hi - ext + delta;
        else if (mode <= 7)
            target = longint'($urandom_range(0, 400 * ONE)) - 200 * ONE;
        else
            target = longint'($signed($urandom));
        if (target > POS_MAX || target < POS_MIN)
            target = longint'($signed($urandom));
        b.position = target[31:0];
        return b;
    endfunction

    task automatic test_reset_bounds();
        send_body(sphere_body(obc_pkg::AXIS_X, ONE, 50 * ONE, 3 * ONE));
        send_body(sphere_body(obc_pkg::AXIS_X, ONE, ONE / 2, -3 * ONE));
        send_body(make_body(obc_pkg::AXIS_Z, 1'b0, 1'b0, 0, 2 * ONE, 3 * ONE, 4 * ONE,
                            ONE, -ONE / 2, 0, 99 * ONE, 5 * ONE));
        send_body(make_body(obc_pkg::AXIS_Y, 1'b1, 1'b1, ONE, 0, 0, 0, 0, 0, 0,
                            -9 * ONE, -ONE));
        send_body(make_body(obc_pkg::AXIS_NONE, 1'b0, 1'b1, ONE, 0, 0, 0, 0, 0, 0,
                            -9 * ONE, -ONE));
    endtask

    task automatic test_field_extremes();
        // widest box with -2.0 components: the final position saturates low
        send_body(make_body(obc_pkg::AXIS_X, 1'b0, 1'b0, 0, MAG_HI, MAG_HI, MAG_HI,
                            -2 * ONE, -2 * ONE, -2 * ONE, COORD_LO, COORD_LO));
        send_body(make_body(obc_pkg::AXIS_Y, 1'b0, 1'b0, MAG_HI, MAG_HI, MAG_HI, 0,
                            ONE, -ONE, 0, COORD_HI, COORD_HI));
        send_body(make_body(obc_pkg::AXIS_Z, 1'b0, 1'b0, 0, 5 * ONE, 7 * ONE, ONE,
                            131071, -131071, 1, 40 * ONE, -ONE));
        send_body(sphere_body(obc_pkg::AXIS_Z, MAG_HI, 0, 0));
        send_body(sphere_body(obc_pkg::AXIS_X, 0, COORD_HI, COORD_HI));
        send_body(sphere_body(obc_pkg::AXIS_Y, 0, COORD_LO, COORD_LO));
    endtask

    task automatic test_floor_slop();
        wait_idle();
        apply_bounds(0, 0, 0, 100 * ONE, 100 * ONE, 100 * ONE, ONE / 2);
        send_body(sphere_body(obc_pkg::AXIS_Y, ONE, 3 * ONE / 4, -ONE));
        send_body(sphere_body(obc_pkg::AXIS_Y, ONE, ONE / 4, -ONE));
        send_body(sphere_body(obc_pkg::AXIS_Y, ONE, ONE / 2, -ONE));
        // slop is ignored off the Y axis
        send_body(sphere_body(obc_pkg::AXIS_X, ONE, 3 * ONE / 4, -ONE));
        send_body(sphere_body(obc_pkg::AXIS_Z, ONE, 3 * ONE / 4, -ONE));
    endtask

    task automatic test_crossed_bounds();
        wait_idle();
        apply_bounds(60 * ONE, 60 * ONE, 0, 40 * ONE, 40 * ONE, 100 * ONE, 0);
        send_body(sphere_body(obc_pkg::AXIS_X, ONE, 50 * ONE, -ONE));
        send_body(sphere_body(obc_pkg::AXIS_X, ONE, 50 * ONE, 2 * ONE));
        send_body(sphere_body(obc_pkg::AXIS_Y, 0, 70 * ONE, ONE));
    endtask

    task automatic test_extreme_bounds();
        wait_idle();
        apply_bounds(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI, MAG_HI);
        // unused index must leave the bounds alone
        write_reg(obc_pkg::REG_NONE, 32'h1234_5678);
        send_body(sphere_body(obc_pkg::AXIS_Y, MAG_HI, COORD_LO, -ONE));
        send_body(sphere_body(obc_pkg::AXIS_X, MAG_HI, COORD_LO, -ONE));
        send_body(sphere_body(obc_pkg::AXIS_X, MAG_HI, COORD_HI, ONE));
        wait_idle();
        apply_bounds(COORD_HI, COORD_HI, COORD_HI, COORD_LO, COORD_LO, COORD_LO, 0);
        send_body(sphere_body(obc_pkg::AXIS_X, MAG_HI, 0, ONE));
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 0)
                steady = ($urandom_range(0, 3) == 0);
            send_body(random_body());
        end
        steady = 1'b0;
    endtask

    task automatic test_random_sweep();
        wait_idle();
        apply_bounds(obc_pkg::BOUND_MIN_RESET, obc_pkg::BOUND_MIN_RESET,
                     obc_pkg::BOUND_MIN_RESET, obc_pkg::BOUND_MAX_RESET,
                     obc_pkg::BOUND_MAX_RESET, obc_pkg::BOUND_MAX_RESET, 0);
        run_random(290);
        wait_idle();
        apply_bounds(-50 * ONE, 0, -20 * ONE, 50 * ONE, 80 * ONE, 20 * ONE, ONE / 4);
        run_random(290);
        wait_idle();
        apply_bounds(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI, MAG_HI);
        run_random(250);
        wait_idle();
        apply_bounds(COORD_HI, COORD_HI, COORD_HI, COORD_LO, COORD_LO, COORD_LO, 0);
        run_random(200);
        wait_idle();
        apply_bounds(10 * ONE, 30 * ONE, -5 * ONE, -10 * ONE, 20 * ONE, -15 * ONE, 2 * ONE);
        run_random(250);
        wait_idle();
        apply_bounds(5 * ONE, 5 * ONE, -5 * ONE, 5 * ONE, 5 * ONE, -5 * ONE, ONE);
        run_random(200);
        for (int k = 0; k < 2; k++)
        begin
            wait_idle();
            apply_bounds($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            run_random(140);
        end
    endtask

    initial
    begin
        body_item_t idle_word;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = obc_pkg::REG_MIN_X;
        cfg_wdata = '0;
        item_ch.valid = 1'b0;
        idle_word = make_body(obc_pkg::AXIS_X, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drive_payload(idle_word);
        for (int i = 0; i < 3; i++)
        begin
            cfg_min[i] = obc_pkg::BOUND_MIN_RESET;
            cfg_max[i] = obc_pkg::BOUND_MAX_RESET;
        end
        cfg_slop = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_bounds();
        test_field_extremes();
        test_floor_slop();
        test_crossed_bounds();
        test_extreme_bounds();
        test_random_sweep();

        wait_idle();
        if (fail_count == 0)
            $display("[obb_world_bounds_clamp] OK");
        else
            $display("[obb_world_bounds_clamp] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/obc_pkg.sv
hw/rtl/obc_if.sv
hw/rtl/obc_front.sv
hw/rtl/obc_queue.sv
hw/rtl/obc_back.sv
hw/rtl/obb_world_bounds_clamp.sv
hw/rtl/obc_checker.sv
bench/obb_world_bounds_clamp_tb.sv
